>>> src/tsl_pkg.sv
package tsl_pkg;

  localparam int unsigned MAX_LEN = 65536;

  localparam int POS_W = 17;
  localparam int EXT_W = 18;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [EXT_W-1:0] MAX_LEN_C = EXT_W'(MAX_LEN);

  localparam logic [7:0]  CT_HANDSHAKE    = 8'h16;
  localparam logic [7:0]  VER_MAJOR       = 8'h03;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] EXT_SNI         = 16'h0000;

  localparam int REC_HDR_LEN = 5;
  localparam int HS_HDR_LEN  = 4;
  localparam int VERSION_LEN = 2;
  localparam int RANDOM_LEN  = 32;
  localparam int EXT_HDR_LEN = 4;
  localparam int SNI_MIN_LEN = 5;
  localparam int SNI_LIST_HDR = 3;

  localparam logic [EXT_W-1:0] SKIP_REC = EXT_W'(REC_HDR_LEN);
  localparam logic [EXT_W-1:0] SKIP_HELLO =
    EXT_W'(REC_HDR_LEN + HS_HDR_LEN + VERSION_LEN + RANDOM_LEN);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] split_offset;
  } rsp_t;

  typedef enum logic [4:0] {
    PH_TYPE,
    PH_VER,
    PH_HSTYPE,
    PH_SID,
    PH_CS_HI,
    PH_CS_LO,
    PH_CM,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_ET_HI,
    PH_ET_LO,
    PH_EL_HI_O,
    PH_EL_LO_O,
    PH_EL_HI_S,
    PH_EL_LO_S,
    PH_NL_HI,
    PH_NL_LO,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic valid;
    req_t data;
  } in_stage_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } result_t;

endpackage

>>> src/tsl_in_reg.sv
module tsl_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tsl_pkg::req_t     req,
  input  logic              advance,
  output tsl_pkg::in_stage_t stage
);
  import tsl_pkg::*;

  logic load;

  assign req_stall = stage.valid && !advance;
  assign load      = !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= req_valid;
    end
    if (load && req_valid) begin
      stage.data <= req;
    end
  end

endmodule

>>> src/tsl_parser.sv
module tsl_parser (
  input  logic               clk,
  input  logic               rst,
  input  tsl_pkg::in_stage_t stage,
  input  logic               advance,
  output tsl_pkg::result_t   result
);
  import tsl_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  phase_t           phase, phase_next;
  logic [7:0]       acc, acc_next;
  logic [EXT_W-1:0] skip, skip_next;
  logic [EXT_W-1:0] ext_end, ext_end_next;
  logic [EXT_W-1:0] host, host_next;
  logic [EXT_W-1:0] need, need_next;
  logic             failed, failed_next;
  logic             sni, sni_next;

  logic             step;
  logic [7:0]       b;
  logic [EXT_W-1:0] p18;
  logic [15:0]      v16;
  logic [EXT_W-1:0] sum;
  logic             take;
  logic             fail_mid;
  logic [EXT_W-1:0] len;
  logic [EXT_W:0]   hs1;
  logic [EXT_W:0]   off;
  logic             ok;

  assign step = stage.valid && advance;
  assign b    = stage.data.payload_byte;
  assign p18  = {1'b0, pos};
  assign v16  = (phase == PH_SID || phase == PH_CM) ? {8'h00, b} : {acc, b};
  // shared adder: position past this byte plus the field just read
  assign sum  = p18 + EXT_W'(1) + {2'b00, v16};
  assign take = !failed && phase != PH_DONE && p18 >= skip;

  always_comb begin
    phase_next   = phase;
    acc_next     = acc;
    skip_next    = skip;
    ext_end_next = ext_end;
    host_next    = host;
    need_next    = need;
    sni_next     = sni;
    fail_mid     = failed;
    pos_next     = pos;

    if (take) begin
      case (phase)
        PH_TYPE: begin
          if (b != CT_HANDSHAKE) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_VER;
          end
        end
        PH_VER: begin
          if (b != VER_MAJOR) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            skip_next  = SKIP_REC;
            phase_next = PH_HSTYPE;
          end
        end
        PH_HSTYPE: begin
          if (b != HS_CLIENT_HELLO) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            skip_next  = SKIP_HELLO;
            phase_next = PH_SID;
          end
        end
        PH_SID: begin
          skip_next  = sum;
          phase_next = PH_CS_HI;
        end
        PH_CS_HI: begin
          acc_next   = b;
          phase_next = PH_CS_LO;
        end
        PH_CS_LO: begin
          skip_next  = sum;
          phase_next = PH_CM;
        end
        PH_CM: begin
          skip_next  = sum;
          phase_next = PH_EXT_HI;
        end
        PH_EXT_HI: begin
          acc_next   = b;
          phase_next = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          ext_end_next = sum;
          if (v16 < 16'(EXT_HDR_LEN)) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_ET_HI;
          end
        end
        PH_ET_HI: begin
          acc_next   = b;
          phase_next = PH_ET_LO;
        end
        PH_ET_LO: begin
          phase_next = (v16 == EXT_SNI) ? PH_EL_HI_S : PH_EL_HI_O;
        end
        PH_EL_HI_O: begin
          acc_next   = b;
          phase_next = PH_EL_LO_O;
        end
        PH_EL_LO_O: begin
          // next extension header must also fit
          if ({1'b0, sum} + (EXT_W+1)'(EXT_HDR_LEN) > {1'b0, ext_end}) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            skip_next  = sum;
            phase_next = PH_ET_HI;
          end
        end
        PH_EL_HI_S: begin
          acc_next   = b;
          phase_next = PH_EL_LO_S;
        end
        PH_EL_LO_S: begin
          if (sum > ext_end || v16 < 16'(SNI_MIN_LEN)) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            need_next  = sum;
            skip_next  = p18 + EXT_W'(1 + SNI_LIST_HDR);
            phase_next = PH_NL_HI;
          end
        end
        PH_NL_HI: begin
          acc_next   = b;
          phase_next = PH_NL_LO;
        end
        PH_NL_LO: begin
          if (v16 == 16'h0000) begin
            fail_mid   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            host_next = p18 + EXT_W'(1);
            if (sum > need) begin
              need_next = sum;
            end
            sni_next   = 1'b1;
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    if (p18 >= MAX_LEN_C) begin
      fail_mid = 1'b1;
    end

    failed_next = fail_mid;
    if (pos >= POS_MAX) begin
      failed_next = 1'b1;
    end else begin
      pos_next = pos + POS_W'(1);
    end
  end

  assign len = p18 + EXT_W'(1);
  assign hs1 = {1'b0, host_next} + (EXT_W+1)'(1);
  assign off = (hs1 < {1'b0, len}) ? hs1 : {1'b0, host_next};
  assign ok  = !fail_mid && sni_next && need_next <= len && off <= (EXT_W+1)'(16'hFFFF);

  assign result.valid             = step && stage.data.last;
  assign result.data.found        = ok;
  assign result.data.split_offset = ok ? off[15:0] : 16'h0000;

  always_ff @(posedge clk) begin
    if (rst || (step && stage.data.last)) begin
      pos     <= '0;
      phase   <= PH_TYPE;
      acc     <= '0;
      skip    <= '0;
      ext_end <= '0;
      host    <= '0;
      need    <= '0;
      failed  <= 1'b0;
      sni     <= 1'b0;
    end else if (step) begin
      pos     <= pos_next;
      phase   <= phase_next;
      acc     <= acc_next;
      skip    <= skip_next;
      ext_end <= ext_end_next;
      host    <= host_next;
      need    <= need_next;
      failed  <= failed_next;
      sni     <= sni_next;
    end
  end

endmodule

>>> src/tsl_out_reg.sv
module tsl_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  tsl_pkg::result_t result,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output tsl_pkg::rsp_t    rsp,
  output logic             full
);
  import tsl_pkg::*;

  assign full = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      rsp <= result.data;
    end
  end

endmodule

>>> src/tls_sni_split_locator.sv
// A result transaction is offered in the cycle after the parser takes the byte flagged last.
// Throughput: one payload byte per cycle; the only stall comes from a held result
// blocking the next last byte in the input register.
// Reset (rst, synchronous): empties both registers and returns the parser to the
// record-header phase; the parser also self-resets after every last byte.
module tls_sni_split_locator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tsl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tsl_pkg::rsp_t rsp
);
  import tsl_pkg::*;

  in_stage_t stage;
  result_t   result;
  logic      full;
  logic      advance;

  // only a last byte produces a transaction, so only it waits on the output
  assign advance = !(stage.data.last && full);

  tsl_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .advance   (advance),
    .stage     (stage)
  );

  tsl_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

  tsl_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .full      (full)
  );

endmodule
